// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the clock face renderer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock face renderer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock face renderer: assertion failed");

`endif

// File: rtl/core/cfr_pkg.sv
// Types, constants and glyph helper functions for the clock face renderer.
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 5;

    typedef logic [63:0] frame_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TWELVE_HOUR_MODE = 3'd0,
        REG_NIGHT_START_HOUR = 3'd1,
        REG_NIGHT_END_HOUR   = 3'd2,
        REG_DAY_BRIGHTNESS   = 3'd3,
        REG_NIGHT_BRIGHTNESS = 3'd4,
        REG_NIGHT_BLANK      = 3'd5
    } cfr_reg_idx_t;

    typedef struct packed {
        logic       twelve_hour_mode;
        logic [4:0] night_start_hour;
        logic [4:0] night_end_hour;
        logic [3:0] day_brightness;
        logic [3:0] night_brightness;
        logic       night_blank;
    } cfr_cfg_t;

    // What the poll stage hands to the render stage.
    typedef struct packed {
        logic       blank;
        logic       brightness_write;
        logic [3:0] brightness;
        logic [4:0] hour_disp;
        logic [5:0] minute;
    } cfr_face_t;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } cfr_digits_t;

    localparam logic [4:0] RESET_NIGHT_START = 5'd22;
    localparam logic [4:0] RESET_NIGHT_END   = 5'd6;
    localparam logic [3:0] RESET_DAY_LEVEL   = 4'd15;
    localparam logic [3:0] RESET_NIGHT_LEVEL = 4'd1;

    localparam frame_t COLON_UPPER = 64'h0000_0000_0080_0000;
    localparam frame_t COLON_LOWER = 64'h0000_0080_0000_0000;

    function automatic frame_t font_glyph(input logic [3:0] digit);
        frame_t g;
        case (digit)
            4'd0:    g = 64'h001c_2222_2222_221c;
            4'd1:    g = 64'h0010_1010_1214_1810;
            4'd2:    g = 64'h003e_0408_1022_2418;
            4'd3:    g = 64'h001c_2220_3820_221c;
            4'd4:    g = 64'h0020_207e_2428_3020;
            4'd5:    g = 64'h001c_2220_3c02_023e;
            4'd6:    g = 64'h001c_2222_1e02_0418;
            4'd7:    g = 64'h0002_0408_1020_203e;
            4'd8:    g = 64'h001c_2222_1c22_221c;
            4'd9:    g = 64'h0004_0810_3c22_221c;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] columns_lit(input frame_t g);
        logic [7:0] c;
        c = '0;
        for (int r = 0; r < 8; r++) begin
            c = c | g[8*r +: 8];
        end
        return c;
    endfunction

    // Highest set column, 0 when nothing is lit.
    function automatic logic [2:0] highest_col(input logic [7:0] c);
        logic [2:0] h;
        h = '0;
        for (int i = 0; i < 8; i++) begin
            if (c[i]) begin
                h = 3'(i);
            end
        end
        return h;
    endfunction

    // Lowest set column, 0 when nothing is lit.
    function automatic logic [2:0] lowest_col(input logic [7:0] c);
        logic [2:0] l;
        l = '0;
        for (int i = 7; i >= 0; i--) begin
            if (c[i]) begin
                l = 3'(i);
            end
        end
        return l;
    endfunction

    function automatic frame_t rows_up(input frame_t g, input logic [2:0] n);
        frame_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = g[8*i +: 8] << n;
        end
        return r;
    endfunction

    function automatic frame_t rows_down(input frame_t g, input logic [2:0] n);
        frame_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = g[8*i +: 8] >> n;
        end
        return r;
    endfunction

    // Tens digits sit with their rightmost lit column on column 6.
    function automatic frame_t shift_tens_glyph(input frame_t g);
        logic [2:0] c;
        frame_t     r;
        c = highest_col(columns_lit(g));
        if (c == 3'd7) begin
            r = rows_down(g, 3'd1);
        end else if (c >= 3'd3 && c <= 3'd5) begin
            r = rows_up(g, 3'd6 - c);
        end else begin
            r = g;
        end
        return r;
    endfunction

    // Units digits sit with their leftmost lit column on column 1.
    function automatic frame_t shift_units_glyph(input frame_t g);
        logic [2:0] c;
        frame_t     r;
        c = lowest_col(columns_lit(g));
        if (c == 3'd0) begin
            r = rows_up(g, 3'd1);
        end else if (c >= 3'd2 && c <= 3'd4) begin
            r = rows_down(g, c - 3'd1);
        end else begin
            r = g;
        end
        return r;
    endfunction

    // Decimal split of a value below 64 by a chain of compares.
    function automatic cfr_digits_t decimal_split(input logic [5:0] v);
        cfr_digits_t d;
        logic [2:0]  t;
        logic [5:0]  tens_x10;
        t = '0;
        for (int k = 1; k < 7; k++) begin
            if (v >= 6'(10 * k)) begin
                t = 3'(k);
            end
        end
        tens_x10 = {t, 3'b000} + {2'b00, t, 1'b0};
        d.tens   = t;
        d.units  = 4'(v - tens_x10);
        return d;
    endfunction

endpackage

// File: rtl/core/cfr_stream_if.sv
// Valid/ready channel interfaces for the poll input and the face output.
`timescale 1ns / 1ps

interface cfr_poll_if;
    logic       valid;
    logic       ready;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       synced;
    logic       touch;

    modport source (output valid, output hour, output minute, output synced,
                    output touch, input ready);
    modport sink   (input valid, input hour, input minute, input synced,
                    input touch, output ready);
endinterface

interface cfr_face_if;
    logic        valid;
    logic        ready;
    logic        blank;
    logic        brightness_write;
    logic [3:0]  brightness;
    logic [63:0] frame_hour_tens;
    logic [63:0] frame_hour_units;
    logic [63:0] frame_minute_tens;
    logic [63:0] frame_minute_units;

    modport source (output valid, output blank, output brightness_write,
                    output brightness, output frame_hour_tens, output frame_hour_units,
                    output frame_minute_tens, output frame_minute_units, input ready);
    modport sink   (input valid, input blank, input brightness_write,
                    input brightness, input frame_hour_tens, input frame_hour_units,
                    input frame_minute_tens, input frame_minute_units, output ready);
endinterface

// File: rtl/core/clock_face_renderer.sv
// A poll beat that produces a face is registered in the poll stage and then in the render stage's result register.
// Throughput: one poll beat per cycle while the faces are taken; the poll stage and the render stage each hold
// one item, and the output register lets a new poll enter while a face waits to be taken.
// Reset (rst_n, asynchronous, active low) clears both valid flags, the stored time and
// the display-off flag, and loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module clock_face_renderer (
    input  logic                             clk,
    input  logic                             rst_n,
    cfr_poll_if.sink                         poll,
    cfr_face_if.source                       face,
    input  logic                             wr_en,
    input  logic [cfr_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]   wr_data
);

    // Configuration as held in the register file; the user must write it only while idle (the block
    // itself does not enforce this), so the poll stage may read it directly when a beat is accepted.
    cfr_pkg::cfr_cfg_t  cfg;

    // Hand-over between the poll stage and the render stage.
    logic               stage_valid;
    logic               stage_ready;
    cfr_pkg::cfr_face_t stage_face;

    cfr_config_regs u_config_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // The poll stage applies the touch toggle, drops polls that change nothing,
    // updates the stored time and decides blanking and the brightness level.
    cfr_poll_ctrl u_poll_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .poll       (poll),
        .face_valid (stage_valid),
        .face_ready (stage_ready),
        .face       (stage_face)
    );

    // The render stage turns the digits into four aligned glyph frames and
    // registers the finished face for the output channel.
    cfr_render u_render (
        .clk        (clk),
        .rst_n      (rst_n),
        .face_valid (stage_valid),
        .face_ready (stage_ready),
        .face       (stage_face),
        .out        (face)
    );

endmodule

// File: rtl/core/cfr_config_regs.sv
// Configuration register file written through the plain write port.
`timescale 1ns / 1ps

module cfr_config_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [cfr_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]    wr_data,
    output cfr_pkg::cfr_cfg_t                 cfg
);

    cfr_pkg::cfr_cfg_t cfg_reg;
    cfr_pkg::cfr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfr_pkg::cfr_reg_idx_t'(wr_index))
                cfr_pkg::REG_TWELVE_HOUR_MODE: cfg_next.twelve_hour_mode = wr_data[0];
                cfr_pkg::REG_NIGHT_START_HOUR: cfg_next.night_start_hour = wr_data[4:0];
                cfr_pkg::REG_NIGHT_END_HOUR:   cfg_next.night_end_hour   = wr_data[4:0];
                cfr_pkg::REG_DAY_BRIGHTNESS:   cfg_next.day_brightness   = wr_data[3:0];
                cfr_pkg::REG_NIGHT_BRIGHTNESS: cfg_next.night_brightness = wr_data[3:0];
                cfr_pkg::REG_NIGHT_BLANK:      cfg_next.night_blank      = wr_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.twelve_hour_mode <= 1'b0;
            cfg_reg.night_start_hour <= cfr_pkg::RESET_NIGHT_START;
            cfg_reg.night_end_hour   <= cfr_pkg::RESET_NIGHT_END;
            cfg_reg.day_brightness   <= cfr_pkg::RESET_DAY_LEVEL;
            cfg_reg.night_brightness <= cfr_pkg::RESET_NIGHT_LEVEL;
            cfg_reg.night_blank      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/cfr_poll_ctrl.sv
// Poll stage: touch toggle, change detection, blanking and brightness choice.
`timescale 1ns / 1ps

module cfr_poll_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfr_pkg::cfr_cfg_t     cfg,
    cfr_poll_if.sink              poll,
    output logic                  face_valid,
    input  logic                  face_ready,
    output cfr_pkg::cfr_face_t    face
);

    logic               valid_reg;
    logic               valid_next;
    cfr_pkg::cfr_face_t face_reg;
    cfr_pkg::cfr_face_t face_next;
    logic [4:0]         last_hour_reg;
    logic [4:0]         last_hour_next;
    logic [5:0]         last_minute_reg;
    logic [5:0]         last_minute_next;
    logic               screen_off_reg;
    logic               screen_off_next;

    logic               accept;
    logic               same_time;
    logic               emit;
    logic               night;
    logic [4:0]         hour_12;

    assign poll.ready = !valid_reg || face_ready;
    assign accept     = poll.valid && poll.ready;
    assign same_time  = (poll.hour == last_hour_reg) && (poll.minute == last_minute_reg);
    assign emit       = !poll.synced || !same_time || poll.touch;
    assign night      = (poll.hour > cfg.night_start_hour) || (poll.hour < cfg.night_end_hour);

    always_comb
    begin
        hour_12 = poll.hour;
        if (poll.hour > 5'd12)
        begin
            hour_12 = poll.hour - 5'd12;
        end
        if (hour_12 == 5'd0)
        begin
            hour_12 = 5'd12;
        end
    end

    always_comb
    begin
        valid_next       = valid_reg && !face_ready;
        face_next        = face_reg;
        last_hour_next   = last_hour_reg;
        last_minute_next = last_minute_reg;
        screen_off_next  = screen_off_reg;
        if (accept)
        begin
            screen_off_next = screen_off_reg ^ poll.touch;
            valid_next      = emit;
            face_next.hour_disp        = cfg.twelve_hour_mode ? hour_12 : poll.hour;
            face_next.minute           = poll.minute;
            face_next.blank            = 1'b1;
            face_next.brightness_write = 1'b0;
            face_next.brightness       = 4'd0;
            if (poll.synced && emit)
            begin
                last_hour_next   = poll.hour;
                last_minute_next = poll.minute;
                if (!screen_off_next)
                begin
                    face_next.brightness_write = 1'b1;
                    face_next.brightness = night ? cfg.night_brightness : cfg.day_brightness;
                    face_next.blank      = night && cfg.night_blank;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            last_hour_reg   <= '0;
            last_minute_reg <= '0;
            screen_off_reg  <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            last_hour_reg   <= last_hour_next;
            last_minute_reg <= last_minute_next;
            screen_off_reg  <= screen_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg <= face_next;
    end

    assign face_valid = valid_reg;
    assign face       = face_reg;

endmodule

// File: rtl/core/cfr_render.sv
// Render stage: digit split, font lookup, column alignment and the result register.
`timescale 1ns / 1ps

module cfr_render (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  face_valid,
    output logic                  face_ready,
    input  cfr_pkg::cfr_face_t    face,
    cfr_face_if.source            out
);

    logic                 valid_reg;
    logic                 valid_next;
    logic                 blank_reg;
    logic                 bw_reg;
    logic [3:0]           level_reg;
    cfr_pkg::frame_t      fht_reg;
    cfr_pkg::frame_t      fhu_reg;
    cfr_pkg::frame_t      fmt_reg;
    cfr_pkg::frame_t      fmu_reg;
    cfr_pkg::frame_t      fht_next;
    cfr_pkg::frame_t      fhu_next;
    cfr_pkg::frame_t      fmt_next;
    cfr_pkg::frame_t      fmu_next;

    cfr_pkg::cfr_digits_t hour_dig;
    cfr_pkg::cfr_digits_t min_dig;
    cfr_pkg::frame_t      hu_aligned;
    logic                 take;

    assign face_ready = !valid_reg || out.ready;
    assign take       = face_valid && face_ready;
    assign hour_dig   = cfr_pkg::decimal_split({1'b0, face.hour_disp});
    assign min_dig    = cfr_pkg::decimal_split(face.minute);
    assign hu_aligned = cfr_pkg::shift_units_glyph(cfr_pkg::font_glyph(hour_dig.units));

    always_comb
    begin
        fht_next = '0;
        fhu_next = '0;
        fmt_next = '0;
        fmu_next = '0;
        if (!face.blank)
        begin
            fht_next = cfr_pkg::shift_tens_glyph(cfr_pkg::font_glyph({1'b0, hour_dig.tens}));
            fmt_next = cfr_pkg::shift_tens_glyph(cfr_pkg::font_glyph({1'b0, min_dig.tens}));
            fmu_next = cfr_pkg::shift_units_glyph(cfr_pkg::font_glyph(min_dig.units));
            fhu_next = hu_aligned;
            // Colon only where the hour units glyph leaves columns 6 and 7 free.
            if (cfr_pkg::highest_col(cfr_pkg::columns_lit(hu_aligned)) <= 3'd5)
            begin
                fhu_next = hu_aligned | cfr_pkg::COLON_UPPER | cfr_pkg::COLON_LOWER;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg && !out.ready;
        if (take)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blank_reg <= face.blank;
            bw_reg    <= face.brightness_write;
            level_reg <= face.brightness;
            fht_reg   <= fht_next;
            fhu_reg   <= fhu_next;
            fmt_reg   <= fmt_next;
            fmu_reg   <= fmu_next;
        end
    end

    assign out.valid              = valid_reg;
    assign out.blank              = blank_reg;
    assign out.brightness_write   = bw_reg;
    assign out.brightness         = level_reg;
    assign out.frame_hour_tens    = fht_reg;
    assign out.frame_hour_units   = fhu_reg;
    assign out.frame_minute_tens  = fmt_reg;
    assign out.frame_minute_units = fmu_reg;

endmodule

// File: rtl/core/cfr_checker.sv
// Port-level checker for the clock face renderer and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        face_valid,
    input logic        face_ready,
    input logic        blank,
    input logic        brightness_write,
    input logic [3:0]  brightness,
    input logic [63:0] frame_hour_tens,
    input logic [63:0] frame_hour_units,
    input logic [63:0] frame_minute_tens,
    input logic [63:0] frame_minute_units
);

    logic frames_zero;

    assign frames_zero = (frame_hour_tens == 64'd0) && (frame_hour_units == 64'd0)
                      && (frame_minute_tens == 64'd0) && (frame_minute_units == 64'd0);

    // A stalled beat stays offered.
    `CFR_ASSERT_NEXT(a_face_held, clk, rst_n, face_valid && !face_ready, face_valid)
    // A blank beat carries no picture.
    `CFR_ASSERT_NOW(a_blank_frames, clk, rst_n, face_valid && blank, frames_zero)
    // A drawn face always sets the brightness.
    `CFR_ASSERT_NOW(a_drawn_level, clk, rst_n, face_valid && !blank, brightness_write)
    // No level is given without a brightness write.
    `CFR_ASSERT_NOW(a_level_zero, clk, rst_n, face_valid && !brightness_write,
                    brightness == 4'd0)

endmodule

bind clock_face_renderer cfr_checker u_cfr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .face_valid         (face.valid),
    .face_ready         (face.ready),
    .blank              (face.blank),
    .brightness_write   (face.brightness_write),
    .brightness         (face.brightness),
    .frame_hour_tens    (face.frame_hour_tens),
    .frame_hour_units   (face.frame_hour_units),
    .frame_minute_tens  (face.frame_minute_tens),
    .frame_minute_units (face.frame_minute_units)
);
